FILE: sv/mcct_pkg.sv
package mcct_pkg;

    // Field widths
    localparam int GAP_W     = 10;
    localparam int MIN_W     = 8;
    localparam int SEC_W     = 6;
    localparam int MS_W      = 10;
    localparam int TSR_W     = 11;
    localparam int OPT_W     = 2;
    localparam int CLICK_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    // Register reset values
    localparam logic [GAP_W-1:0] GAP_RESET  = GAP_W'(400);
    localparam logic [MIN_W-1:0] OPT0_RESET = MIN_W'(10);
    localparam logic [MIN_W-1:0] OPT1_RESET = MIN_W'(15);
    localparam logic [MIN_W-1:0] OPT2_RESET = MIN_W'(30);

    // Countdown constants
    localparam logic [SEC_W-1:0] SEC_MAX = SEC_W'(59);
    localparam logic [MS_W-1:0]  MS_MAX  = MS_W'(999);
    localparam logic [TSR_W-1:0] TSR_MAX = {TSR_W{1'b1}};
    localparam logic [OPT_W-1:0] OPT_LAST = OPT_W'(2);

    // Click group classification codes
    typedef enum logic [CLICK_W-1:0] {
        CLICK_NONE   = 2'd0,
        CLICK_SINGLE = 2'd1,
        CLICK_DOUBLE = 2'd2,
        CLICK_TRIPLE = 2'd3
    } click_kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLICK_GAP = 2'd0,
        CFG_OPT_ZERO  = 2'd1,
        CFG_OPT_ONE   = 2'd2,
        CFG_OPT_TWO   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [GAP_W-1:0] click_gap;
        logic [MIN_W-1:0] opt0_min;
        logic [MIN_W-1:0] opt1_min;
        logic [MIN_W-1:0] opt2_min;
    } cfg_t;

    typedef struct packed {
        logic             menu_is_open;
        logic             timer_active;
        logic [OPT_W-1:0] selected_option;
        logic [MIN_W-1:0] left_minutes;
        logic [SEC_W-1:0] left_seconds;
        click_kind_t      click_kind;
        logic             done_pulse;
    } result_t;

endpackage

FILE: sv/mcct_core.sv
module mcct_core
    import mcct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    level,
    input  cfg_t    cfg,
    output result_t res
);

    logic               menu_reg, menu_next;
    logic               run_reg, run_next;
    logic [OPT_W-1:0]   opt_reg, opt_next;
    logic               prev_reg;
    logic [TSR_W-1:0]   tsr_reg, tsr_next;
    logic [CLICK_W-1:0] clicks_reg, clicks_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic [MS_W-1:0]    ms_reg, ms_next;

    logic [MIN_W-1:0]   sel_min;
    logic               classify;
    logic               done;
    click_kind_t        kind;

    // Minutes of the selected option
    always_comb
    begin
        case (opt_reg)
            2'd0:    sel_min = cfg.opt0_min;
            2'd1:    sel_min = cfg.opt1_min;
            default: sel_min = cfg.opt2_min;
        endcase
    end

    // One tick of work: countdown, release detection, classification, expiry
    always_comb
    begin
        menu_next   = menu_reg;
        run_next    = run_reg;
        opt_next    = opt_reg;
        tsr_next    = tsr_reg;
        clicks_next = clicks_reg;
        min_next    = min_reg;
        sec_next    = sec_reg;
        ms_next     = ms_reg;
        kind        = CLICK_NONE;
        done        = 1'b0;
        classify    = 1'b0;

        // remaining time is kept as minutes, seconds and milliseconds
        if (run_reg)
        begin
            if (ms_reg != '0)
            begin
                ms_next = ms_reg - MS_W'(1);
            end
            else if (min_reg != '0 || sec_reg != '0)
            begin
                ms_next = MS_MAX;
                if (sec_reg == '0)
                begin
                    sec_next = SEC_MAX;
                    min_next = min_reg - MIN_W'(1);
                end
                else
                begin
                    sec_next = sec_reg - SEC_W'(1);
                end
            end
        end

        // release edge counts a click, otherwise the gap counter saturates
        if (!prev_reg && level)
        begin
            if (clicks_reg != CLICK_TRIPLE)
            begin
                clicks_next = clicks_reg + CLICK_W'(1);
            end
            tsr_next = '0;
        end
        else if (tsr_reg != TSR_MAX)
        begin
            tsr_next = tsr_reg + TSR_W'(1);
        end

        classify = (clicks_next != '0) && (tsr_next > {1'b0, cfg.click_gap});

        if (classify)
        begin
            kind = click_kind_t'(clicks_next);
            case (kind)
                CLICK_SINGLE:
                begin
                    if (!run_reg)
                    begin
                        if (!menu_reg)
                        begin
                            menu_next = 1'b1;
                            opt_next  = '0;
                        end
                        else
                        begin
                            opt_next = (opt_reg >= OPT_LAST) ? '0 : opt_reg + OPT_W'(1);
                        end
                    end
                end
                CLICK_DOUBLE:
                begin
                    if (menu_reg)
                    begin
                        min_next  = sel_min;
                        sec_next  = '0;
                        ms_next   = '0;
                        run_next  = 1'b1;
                        menu_next = 1'b0;
                    end
                end
                default:
                begin
                    run_next  = 1'b0;
                    menu_next = 1'b0;
                end
            endcase
            clicks_next = '0;
        end

        // expiry once no whole second remains
        if (run_next && min_next == '0 && sec_next == '0)
        begin
            run_next = 1'b0;
            done     = 1'b1;
        end
    end

    // Result of this tick
    always_comb
    begin
        res.menu_is_open    = menu_next;
        res.timer_active    = run_next;
        res.selected_option = opt_next;
        res.left_minutes    = run_next ? min_next : '0;
        res.left_seconds    = run_next ? sec_next : '0;
        res.click_kind      = kind;
        res.done_pulse      = done;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            menu_reg   <= 1'b0;
            run_reg    <= 1'b0;
            opt_reg    <= '0;
            prev_reg   <= 1'b1;
            tsr_reg    <= '0;
            clicks_reg <= '0;
            min_reg    <= '0;
            sec_reg    <= '0;
            ms_reg     <= '0;
        end
        else if (step)
        begin
            menu_reg   <= menu_next;
            run_reg    <= run_next;
            opt_reg    <= opt_next;
            prev_reg   <= level;
            tsr_reg    <= tsr_next;
            clicks_reg <= clicks_next;
            min_reg    <= min_next;
            sec_reg    <= sec_next;
            ms_reg     <= ms_next;
        end
    end

endmodule

FILE: sv/multi_click_countdown_timer_top.sv
// Multi-click countdown timer. Each input transaction is one millisecond tick
// carrying the sampled active-low button level; each tick yields exactly one
// output transaction with the menu/run flags, selected option, remaining
// minutes and seconds (zero when not running), the click group classified on
// that tick and a done pulse. The block takes one tick per clock cycle while
// the output is not stalled. An accepted tick is held in the input register;
// when the output register is free or draining, the state update is applied
// and its result is loaded into the output register. A stalled output holds
// the tick in the input register and stalls the input. The user must write
// configuration registers through cfg_we/cfg_index/cfg_data only while no
// tick is in flight; the block itself does not enforce it.
module multi_click_countdown_timer_top
    import mcct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 button_level,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 menu_is_open,
    output logic                 timer_active,
    output logic [OPT_W-1:0]     selected_option,
    output logic [MIN_W-1:0]     left_minutes,
    output logic [SEC_W-1:0]     left_seconds,
    output logic [CLICK_W-1:0]   click_kind,
    output logic                 done_pulse
);

    cfg_t    cfg_reg;
    logic    in_vld_reg;
    logic    level_reg;
    logic    out_vld_reg;
    result_t res_reg;
    result_t res;
    logic    fire;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.click_gap <= GAP_RESET;
            cfg_reg.opt0_min  <= OPT0_RESET;
            cfg_reg.opt1_min  <= OPT1_RESET;
            cfg_reg.opt2_min  <= OPT2_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CLICK_GAP: cfg_reg.click_gap <= cfg_data[GAP_W-1:0];
                CFG_OPT_ZERO:  cfg_reg.opt0_min  <= cfg_data[MIN_W-1:0];
                CFG_OPT_ONE:   cfg_reg.opt1_min  <= cfg_data[MIN_W-1:0];
                CFG_OPT_TWO:   cfg_reg.opt2_min  <= cfg_data[MIN_W-1:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // Tick is processed when the output register is free or draining
    assign fire     = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            level_reg <= button_level;
        end
    end

    mcct_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (fire),
        .level (level_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid       = out_vld_reg;
    assign menu_is_open    = res_reg.menu_is_open;
    assign timer_active    = res_reg.timer_active;
    assign selected_option = res_reg.selected_option;
    assign left_minutes    = res_reg.left_minutes;
    assign left_seconds    = res_reg.left_seconds;
    assign click_kind      = res_reg.click_kind;
    assign done_pulse      = res_reg.done_pulse;

endmodule

FILE: tb/tb_multi_click_countdown_timer_top.sv
`timescale 1ns / 100ps

module tb_multi_click_countdown_timer_top;
    import mcct_pkg::*;

    localparam int SECS_W       = 14;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_LIMIT   = 4000;

    // Tracks the timer state tick by tick and checks every output transaction
    class timer_scoreboard;
        logic [GAP_W-1:0]   gap;
        logic [MIN_W-1:0]   opt_min [3];
        logic               menu;
        logic               running;
        logic [OPT_W-1:0]   opt;
        logic               prev_level;
        logic [TSR_W-1:0]   since_release;
        logic [CLICK_W-1:0] clicks;
        logic [SECS_W-1:0]  secs;
        logic [MS_W-1:0]    ms;
        result_t            predicted_outputs [$];
        int                 errors;
        int                 ticks;
        int                 checked;
        int                 expiries;
        int                 kinds_seen [4];

        function new();
            gap           = GAP_RESET;
            opt_min[0]    = OPT0_RESET;
            opt_min[1]    = OPT1_RESET;
            opt_min[2]    = OPT2_RESET;
            menu          = 1'b0;
            running       = 1'b0;
            opt           = '0;
            prev_level    = 1'b1;
            since_release = '0;
            clicks        = '0;
            secs          = '0;
            ms            = '0;
            errors        = 0;
            ticks         = 0;
            checked       = 0;
            expiries      = 0;
            foreach (kinds_seen[i]) kinds_seen[i] = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] value);
            case (idx)
                CFG_CLICK_GAP: gap        = value[GAP_W-1:0];
                CFG_OPT_ZERO:  opt_min[0] = value[MIN_W-1:0];
                CFG_OPT_ONE:   opt_min[1] = value[MIN_W-1:0];
                default:       opt_min[2] = value[MIN_W-1:0];
            endcase
        endfunction

        function int pending();
            return predicted_outputs.size();
        endfunction

        // One millisecond tick: countdown, release detection, classification, expiry
        function void predict_tick(logic level);
            result_t           r;
            click_kind_t       kind;
            logic              done;
            logic [SECS_W-1:0] left;
            kind = CLICK_NONE;
            done = 1'b0;
            if (running)
            begin
                if (ms != '0)
                    ms = ms - 1'b1;
                else if (secs != '0)
                begin
                    secs = secs - 1'b1;
                    ms   = MS_MAX;
                end
            end
            if (!prev_level && level)
            begin
                if (clicks != CLICK_TRIPLE)
                    clicks = clicks + 1'b1;
                since_release = '0;
            end
            else if (since_release != TSR_MAX)
            begin
                since_release = since_release + 1'b1;
            end
            if (clicks != '0 && since_release > {1'b0, gap})
            begin
                kind = click_kind_t'(clicks);
                case (kind)
                    CLICK_SINGLE:
                    begin
                        // ignored while the countdown runs
                        if (!running)
                        begin
                            if (!menu)
                            begin
                                menu = 1'b1;
                                opt  = '0;
                            end
                            else
                            begin
                                opt = (opt >= OPT_LAST) ? '0 : opt + 1'b1;
                            end
                        end
                    end
                    CLICK_DOUBLE:
                    begin
                        if (menu)
                        begin
                            secs    = SECS_W'(opt_min[opt] * 60);
                            ms      = '0;
                            running = 1'b1;
                            menu    = 1'b0;
                        end
                    end
                    default:
                    begin
                        running = 1'b0;
                        menu    = 1'b0;
                    end
                endcase
                clicks = '0;
            end
            if (running && secs == '0)
            begin
                running = 1'b0;
                done    = 1'b1;
            end
            prev_level = level;
            left = running ? secs : '0;
            r.menu_is_open    = menu;
            r.timer_active    = running;
            r.selected_option = opt;
            r.left_minutes    = MIN_W'(left / 60);
            r.left_seconds    = SEC_W'(left % 60);
            r.click_kind      = kind;
            r.done_pulse      = done;
            predicted_outputs.push_back(r);
            kinds_seen[kind]++;
            if (done)
                expiries++;
            ticks++;
        endfunction

        function void compare_field(string field, logic [MIN_W-1:0] want,
                                    logic [MIN_W-1:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (predicted_outputs.size() == 0)
            begin
                $error("output transaction with no tick outstanding");
                errors++;
                return;
            end
            want = predicted_outputs.pop_front();
            checked++;
            compare_field("menu_is_open", want.menu_is_open, got.menu_is_open);
            compare_field("timer_active", want.timer_active, got.timer_active);
            compare_field("selected_option", want.selected_option, got.selected_option);
            compare_field("left_minutes", want.left_minutes, got.left_minutes);
            compare_field("left_seconds", want.left_seconds, got.left_seconds);
            compare_field("click_kind", want.click_kind, got.click_kind);
            compare_field("done_pulse", want.done_pulse, got.done_pulse);
        endfunction

        function void check_drained();
            if (predicted_outputs.size() != 0)
            begin
                $error("%0d ticks never produced an output transaction",
                       predicted_outputs.size());
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 button_level;
    logic                 out_valid;
    logic                 out_stall;
    logic                 menu_is_open;
    logic                 timer_active;
    logic [OPT_W-1:0]     selected_option;
    logic [MIN_W-1:0]     left_minutes;
    logic [SEC_W-1:0]     left_seconds;
    logic [CLICK_W-1:0]   click_kind;
    logic                 done_pulse;

    timer_scoreboard sb;
    bit              bursts_on     = 1'b1;
    bit              hold_request  = 1'b0;
    int              cur_gap       = GAP_RESET;
    int              tick_count    = 0;
    int              config_writes = 0;

    multi_click_countdown_timer_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .button_level    (button_level),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .menu_is_open    (menu_is_open),
        .timer_active    (timer_active),
        .selected_option (selected_option),
        .left_minutes    (left_minutes),
        .left_seconds    (left_seconds),
        .click_kind      (click_kind),
        .done_pulse      (done_pulse)
    );

    always #4 clk = ~clk;

    // Offer one tick, with an occasional idle burst in front of it
    task automatic send_tick(logic level);
        int idle_cycles;
        if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            idle_cycles = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (idle_cycles) @(posedge clk);
        end
        in_valid     <= 1'b1;
        button_level <= level;
        do @(posedge clk); while (in_stall);
        sb.predict_tick(level);
        tick_count++;
    endtask

    task automatic send_run(logic level, int count);
        repeat (count) send_tick(level);
    endtask

    // Sender stops and waits until every tick has produced its output
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Write a single register once the block is empty
    task automatic set_one(cfg_idx_t idx, int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DAT_W'(value);
        @(posedge clk);
        sb.write_reg(idx, CFG_DAT_W'(value));
        cfg_we <= 1'b0;
        if (idx == CFG_CLICK_GAP)
            cur_gap = value;
        config_writes++;
    endtask

    task automatic set_config(int gap, int opt0, int opt1, int opt2);
        int vals [4];
        vals = '{gap, opt0, opt1, opt2};
        drain();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= CFG_DAT_W'(vals[i]);
            @(posedge clk);
            sb.write_reg(cfg_idx_t'(i), CFG_DAT_W'(vals[i]));
        end
        cfg_we <= 1'b0;
        cur_gap = gap;
        config_writes++;
    endtask

    // A group of clicks. tight: shortest presses and spacing. split: the spacing
    // before later clicks overruns the gap, so the group breaks apart.
    task automatic click_group(int clicks_n, bit tight, bit split);
        int press;
        int space;
        int room;
        for (int i = 0; i < clicks_n; i++)
        begin
            space = 0;
            if (tight)
            begin
                press = 1;
            end
            else if (i == 0)
            begin
                press = $urandom_range(1, 6);
            end
            else
            begin
                press = (cur_gap >= 4) ? $urandom_range(1, 4) : 1;
                room  = cur_gap - press;
                if (room < 0)
                    room = 0;
                space = $urandom_range(0, (room > 20) ? 20 : room);
                if (split)
                    space = cur_gap - press + 1;
            end
            send_run(1'b1, space);
            send_run(1'b0, press);
            send_tick(1'b1);
        end
        send_run(1'b1, cur_gap + 1 + (tight ? 0 : $urandom_range(0, 2)));
    endtask

    // Mostly well formed click groups, some broken groups and random noise
    task automatic run_random(int n_ticks);
        int start;
        int pick;
        start = tick_count;
        while (tick_count - start < n_ticks)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                click_group($urandom_range(1, 4), 1'b0, 1'b0);
            else if (pick == 7)
                click_group($urandom_range(2, 4), 1'b0, 1'b1);
            else
                repeat ($urandom_range(1, 10)) send_tick($urandom_range(0, 1));
        end
    endtask

    // Output side: check each transaction, stall in bursts or one long hold-off
    initial
    begin : result_sink
        int      stall_left;
        result_t got;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.menu_is_open    = menu_is_open;
                got.timer_active    = timer_active;
                got.selected_option = selected_option;
                got.left_minutes    = left_minutes;
                got.left_seconds    = left_seconds;
                got.click_kind      = click_kind_t'(click_kind);
                got.done_pulse      = done_pulse;
                sb.check_result(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 5);
            end
            out_stall <= (stall_left > 0);
        end
    end

    // Ends the run when no transaction moves on either side for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_multi_click_countdown_timer_top failed");
        $finish;
    end

    initial
    begin : stimulus
        sb = new();
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_CLICK_GAP;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        button_level <= 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset gap: a single opens the menu at option zero
        click_group(1, 1'b1, 1'b0);

        // Short gap only; option zero keeps its reset minutes
        set_one(CFG_CLICK_GAP, 1);
        click_group(2, 1'b1, 1'b0);
        send_run(1'b1, 30);
        click_group(3, 1'b1, 1'b0);

        // Shortest gap that still allows multi-click groups
        set_config(1, 0, 255, 1);
        click_group(1, 1'b1, 1'b0);   // open at option zero
        click_group(1, 1'b1, 1'b0);   // advance to the 255 minute option
        click_group(2, 1'b1, 1'b0);   // start, full minutes field
        click_group(1, 1'b1, 1'b0);   // single while running is ignored
        click_group(4, 1'b1, 1'b0);   // click count saturates, cancel
        click_group(1, 1'b1, 1'b0);
        click_group(2, 1'b1, 1'b0);   // zero minutes expire on the same tick

        // Zero gap: each release is classified on the next tick
        set_config(0, 0, 255, 1);
        repeat (4) click_group(1, 1'b1, 1'b0);

        // Random phases; the first one starts under a long output hold-off
        set_config(3, 0, 1, 2);
        hold_request = 1'b1;
        run_random(110);

        set_config(40, 255, 0, 128);
        run_random(90);

        set_config(12, 2, 255, 0);
        run_random(60);
        drain();
        run_random(60);

        // Closing phase at full rate, no idling on either side
        set_config(6, 0, 3, 255);
        bursts_on = 1'b0;
        run_random(100);

        drain();
        repeat (8) @(posedge clk);
        sb.check_drained();
        $display("%0d ticks over %0d register settings; %0d outputs checked",
                 sb.ticks, config_writes + 1, sb.checked);
        $display("groups: %0d single, %0d double, %0d triple or more; %0d expiries",
                 sb.kinds_seen[CLICK_SINGLE], sb.kinds_seen[CLICK_DOUBLE],
                 sb.kinds_seen[CLICK_TRIPLE], sb.expiries);
        if (sb.errors == 0)
            $display("tb_multi_click_countdown_timer_top passed");
        else
            $display("tb_multi_click_countdown_timer_top failed");
        $finish;
    end

endmodule
